// File: hw/rtl/mls_pkg.sv
// ----------------------------------------------------------------------------
// mls_pkg: shared types and constants of the level sequencer
// opcodes, the classified command that travels from front to back, and the
// layout of one period table word
// ----------------------------------------------------------------------------
package mls_pkg;

  // field widths fixed by the item format
  localparam int TIME_W      = 8;
  localparam int IDX_W       = 6;
  localparam int CHAN_W      = 3;
  localparam int MASK_W      = 8;
  localparam int IN_TDATA_W  = 48;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 32;

  // command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  // opcodes carried in tuser
  localparam logic [IN_TUSER_W-1:0] OP_TICK  = 2'd0;
  localparam logic [IN_TUSER_W-1:0] OP_WRITE = 2'd1;
  localparam logic [IN_TUSER_W-1:0] OP_CHAN  = 2'd2;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_WRITE,
    CMD_CHAN
  } cmd_kind_t;

  // classified command, indexes already wrapped to the table size
  typedef struct packed {
    cmd_kind_t          kind;
    logic [TIME_W-1:0]  now;
    logic [IDX_W-1:0]   entry;
    logic               level;
    logic [TIME_W-1:0]  duration;
    logic [TIME_W-1:0]  reload;
    logic [IDX_W-1:0]   link;
    logic [CHAN_W-1:0]  channel;
    logic               enable;
  } cmd_t;

  // one period table word
  typedef struct packed {
    logic               level;
    logic [TIME_W-1:0]  duration;
    logic [TIME_W-1:0]  reload;
    logic [IDX_W-1:0]   link;
  } period_t;

endpackage

// File: hw/rtl/multichannel_level_sequencer_top.sv
// ----------------------------------------------------------------------------
// multichannel_level_sequencer_top: eight-pin level sequencer
// each pin walks a cyclic chain of periods from a shared table; ticks report
// the port value, changed pins, next event time and halted channels
// ----------------------------------------------------------------------------
// A table write or a channel start or stop is done from the idle state of the
// execution part. A tick visits the channels in turn; a stopped channel is
// skipped, a running one reads its period and evaluates it, once more per
// period advance. The walk is serialised by the single-port period table,
// which each channel reads and, on entering a period, rewrites. The front end
// keeps accepting items into a two-deep queue while a tick runs, and a
// finished result waits in its own register.
// The period table has no reset; a tick must only reach written entries.
// ----------------------------------------------------------------------------
module multichannel_level_sequencer_top
  import mls_pkg::*;
#(
  parameter int CHANNELS = 8,
  parameter int ENTRIES  = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // now[7:0], entry[13:8], level[14], duration[22:15], reload_duration[30:23],
  // next_entry[36:31], channel[39:37], enable[40], zero[47:41]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // op[1:0]
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // port_value[7:0], changed_mask[15:8], next_event_time[23:16],
  // halted_mask[31:24]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic f_valid;
  logic f_ready;
  cmd_t f_cmd;
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  // decode and classify
  mls_front #(
    .CHANNELS (CHANNELS),
    .ENTRIES  (ENTRIES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (f_valid),
    .cmd       (f_cmd),
    .cmd_ready (f_ready)
  );

  // command queue
  mls_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cmd)
  );

  // execution
  mls_back #(
    .CHANNELS (CHANNELS),
    .ENTRIES  (ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (q_valid),
    .cmd        (q_cmd),
    .cmd_ready  (q_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: hw/rtl/mls_front.sv
// ----------------------------------------------------------------------------
// mls_front: input stage of the level sequencer
// accepts stream transactions, decodes the opcode, wraps table indexes and
// drops items that have no effect, then hands a command to the queue
// ----------------------------------------------------------------------------
module mls_front
  import mls_pkg::*;
#(
  parameter int CHANNELS = 8,
  parameter int ENTRIES  = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [IN_TUSER_W-1:0] in_tuser,
  output logic                  cmd_valid,
  output cmd_t                  cmd,
  input  logic                  cmd_ready
);

  // index modulo table size, by conditional subtraction of shifted sizes
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W-1:0] v);
    logic [IDX_W-1:0] r;
    r = v;
    for (int k = IDX_W - 1; k >= 0; k--) begin
      if (32'(r) >= (ENTRIES << k)) begin
        r = r - IDX_W'(ENTRIES << k);
      end
    end
    return r;
  endfunction

  logic              cmd_valid_r;
  cmd_t              cmd_r;
  cmd_t              cmd_nxt;
  logic              keep_nxt;
  logic              accept;
  logic [CHAN_W-1:0] chan;

  assign in_tready = !cmd_valid_r || cmd_ready;
  assign accept    = in_tvalid && in_tready;
  assign chan      = in_tdata[39:37];

  // decode and classify
  always_comb begin
    cmd_nxt.now      = in_tdata[7:0];
    cmd_nxt.entry    = wrap_idx(in_tdata[13:8]);
    cmd_nxt.level    = in_tdata[14];
    cmd_nxt.duration = in_tdata[22:15];
    cmd_nxt.reload   = in_tdata[30:23];
    cmd_nxt.link     = wrap_idx(in_tdata[36:31]);
    cmd_nxt.channel  = chan;
    cmd_nxt.enable   = in_tdata[40];
    cmd_nxt.kind     = CMD_TICK;
    keep_nxt         = 1'b0;
    unique case (in_tuser)
      OP_TICK: begin
        cmd_nxt.kind = CMD_TICK;
        keep_nxt     = 1'b1;
      end
      OP_WRITE: begin
        cmd_nxt.kind = CMD_WRITE;
        keep_nxt     = 1'b1;
      end
      OP_CHAN: begin
        cmd_nxt.kind = CMD_CHAN;
        keep_nxt     = {29'd0, chan} < 32'(CHANNELS);
      end
      default: begin
        keep_nxt = 1'b0;
      end
    endcase
  end

  // command holding register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else if (accept) begin
      cmd_valid_r <= keep_nxt;
    end else if (cmd_ready) begin
      cmd_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign cmd_valid = cmd_valid_r;
  assign cmd       = cmd_r;

endmodule

// File: hw/rtl/mls_queue.sv
// ----------------------------------------------------------------------------
// mls_queue: short command queue between front and back
// lets the input side keep accepting while a tick is being worked off
// ----------------------------------------------------------------------------
module mls_queue
  import mls_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_data
);

  cmd_t               slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;
  logic               do_push;
  logic               do_pop;

  assign push_ready = count_r != Q_CNT_W'(Q_DEPTH);
  assign pop_valid  = count_r != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = slot_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: hw/rtl/mls_back.sv
// ----------------------------------------------------------------------------
// mls_back: execution part of the level sequencer
// owns the period table and the channel state; runs table writes, channel
// starts and stops, and walks the channels one by one on a tick
// ----------------------------------------------------------------------------
module mls_back
  import mls_pkg::*;
#(
  parameter int CHANNELS = 8,
  parameter int ENTRIES  = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cmd_valid,
  input  cmd_t                   cmd,
  output logic                   cmd_ready,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int DEPTH = (ENTRIES < 64) ? ENTRIES : 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int CIW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SW    = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHAN,
    S_READ,
    S_EVAL,
    S_DONE
  } state_t;

  state_t             state_r;

  // channel state
  logic [CHANNELS-1:0] active_r;
  logic [IDX_W-1:0]    ch_entry_r  [CHANNELS];
  logic [TIME_W-1:0]   ch_credit_r [CHANNELS];
  logic [TIME_W-1:0]   last_time_r;
  logic [MASK_W-1:0]   port_r;

  // tick working registers
  logic [CIW-1:0]      c_r;
  logic [TIME_W-1:0]   delta_r;
  logic [TIME_W-1:0]   now_r;
  logic [TIME_W-1:0]   future_r;
  logic [MASK_W-1:0]   changed_r;
  logic [MASK_W-1:0]   vals_r;
  logic [MASK_W-1:0]   halted_r;
  logic [IDX_W-1:0]    e_r;
  logic [TIME_W-1:0]   credit_r;
  logic [SW-1:0]       steps_r;
  logic                entered_r;

  // result register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  // period table, one port
  period_t             mem [DEPTH];
  period_t             rd_word_r;
  logic                mem_we;
  logic [AW-1:0]       mem_addr;
  period_t             mem_wdata;

  // derived values
  logic [TIME_W:0]     sum_nxt;
  logic [TIME_W-1:0]   credit_nxt;
  logic [TIME_W-1:0]   dur_eff;
  logic [TIME_W-1:0]   rem;
  logic                reach;
  logic                at_limit;
  logic                last_ch;
  logic [MASK_W-1:0]   ch_bit;
  logic [MASK_W-1:0]   port_nxt;
  logic [CIW-1:0]      cmd_ch;
  logic                idle_write;
  logic                publish;

  assign cmd_ready  = state_r == S_IDLE;
  assign cmd_ch     = cmd.channel[CIW-1:0];
  assign idle_write = (state_r == S_IDLE) && cmd_valid && (cmd.kind == CMD_WRITE);

  assign sum_nxt    = {1'b0, ch_credit_r[c_r]} + {1'b0, delta_r};
  assign credit_nxt = sum_nxt[TIME_W] ? {TIME_W{1'b1}} : sum_nxt[TIME_W-1:0];
  assign dur_eff    = entered_r ? rd_word_r.reload : rd_word_r.duration;
  assign reach      = credit_r >= dur_eff;
  assign rem        = dur_eff - credit_r;
  assign at_limit   = steps_r == SW'(ENTRIES);
  assign last_ch    = c_r == CIW'(CHANNELS - 1);
  assign ch_bit     = MASK_W'(1) << c_r;
  assign port_nxt   = (port_r & ~changed_r) | vals_r;
  assign publish    = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // memory port control: writes from the idle state or on entering a period
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = e_r[AW-1:0];
    mem_wdata = rd_word_r;
    if (state_r == S_IDLE) begin
      mem_addr  = cmd.entry[AW-1:0];
      mem_we    = idle_write;
      mem_wdata = '{level: cmd.level, duration: cmd.duration,
                    reload: cmd.reload, link: cmd.link};
    end else if (state_r == S_EVAL && entered_r) begin
      mem_we             = 1'b1;
      mem_wdata.duration = rd_word_r.reload;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_word_r <= mem[mem_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        ch_entry_r[i]  <= '0;
        ch_credit_r[i] <= '0;
      end
      last_time_r <= '0;
      port_r      <= '0;
      c_r         <= '0;
      steps_r     <= '0;
      entered_r   <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            unique case (cmd.kind)
              CMD_TICK: begin
                delta_r     <= cmd.now - last_time_r;
                last_time_r <= cmd.now;
                now_r       <= cmd.now;
                c_r         <= '0;
                future_r    <= {TIME_W{1'b1}};
                changed_r   <= '0;
                vals_r      <= '0;
                halted_r    <= '0;
                state_r     <= S_CHAN;
              end
              CMD_CHAN: begin
                if (cmd.enable) begin
                  ch_entry_r[cmd_ch]  <= cmd.entry;
                  ch_credit_r[cmd_ch] <= '0;
                  active_r[cmd_ch]    <= 1'b1;
                end else begin
                  active_r[cmd_ch] <= 1'b0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        // pick up one channel and add elapsed time to its credit
        S_CHAN: begin
          if (active_r[c_r]) begin
            e_r       <= ch_entry_r[c_r];
            credit_r  <= credit_nxt;
            steps_r   <= '0;
            entered_r <= 1'b0;
            state_r   <= S_READ;
          end else if (last_ch) begin
            state_r <= S_DONE;
          end else begin
            c_r <= c_r + 1'b1;
          end
        end
        S_READ: begin
          state_r <= S_EVAL;
        end
        // compare credit with the period and follow the link if it elapsed
        S_EVAL: begin
          if (entered_r) begin
            vals_r <= rd_word_r.level ? (vals_r | ch_bit) : (vals_r & ~ch_bit);
          end
          if (reach && !at_limit) begin
            steps_r   <= steps_r + 1'b1;
            e_r       <= rd_word_r.link;
            credit_r  <= '0;
            changed_r <= changed_r | ch_bit;
            entered_r <= 1'b1;
            state_r   <= S_READ;
          end else begin
            ch_entry_r[c_r]  <= e_r;
            ch_credit_r[c_r] <= credit_r;
            if (reach) begin
              active_r[c_r] <= 1'b0;
              halted_r      <= halted_r | ch_bit;
            end else if (rem < future_r) begin
              future_r <= rem;
            end
            if (last_ch) begin
              state_r <= S_DONE;
            end else begin
              c_r     <= c_r + 1'b1;
              state_r <= S_CHAN;
            end
          end
        end
        // publish the tick result once the output register is free
        S_DONE: begin
          if (publish) begin
            port_r     <= port_nxt;
            out_data_r <= {halted_r, now_r + future_r, changed_r, port_nxt};
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (publish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: bench/multichannel_level_sequencer_top_tb.sv
// ----------------------------------------------------------------------------
// multichannel_level_sequencer_top_tb: regression bench of the level sequencer
// drives table writes, channel starts and stops and ticks over the input
// stream, predicts every tick report with a behavioral copy of the sequencer
// and checks the reports field by field under random stalls on both sides
// ----------------------------------------------------------------------------
module multichannel_level_sequencer_top_tb;
  import mls_pkg::*;

  localparam int NUM_CH  = 8;
  localparam int NUM_ENT = 64;
  localparam logic [IN_TUSER_W-1:0] OP_NONE = 2'd3;
  // the limit leaves room for ticks in which all eight channels walk a full
  // zero chain, plus stalls
  localparam int STALL_LIMIT = 6000;
  localparam int TAIL_CYCLES = 64;

  // one tick report, laid out as out_tdata
  typedef struct packed {
    logic [7:0] halted;
    logic [7:0] next_evt;
    logic [7:0] changed;
    logic [7:0] port;
  } tick_report_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [IN_TUSER_W-1:0]  in_tuser   = OP_TICK;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  multichannel_level_sequencer_top #(
    .CHANNELS(NUM_CH),
    .ENTRIES (NUM_ENT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // shadow of the sequencer state
  bit       lvl_tab   [NUM_ENT];
  bit [7:0] dur_tab   [NUM_ENT];
  bit [7:0] rel_tab   [NUM_ENT];
  bit [5:0] link_tab  [NUM_ENT];
  bit [5:0] ch_pos    [NUM_CH];
  bit       ch_run    [NUM_CH];
  bit [7:0] ch_credit [NUM_CH];
  bit [7:0] prev_now;
  bit [7:0] pins;

  tick_report_t expected_reports[$];

  bit       idle_on = 1'b0;
  bit [7:0] cur_now = '0;
  int       errors = 0;
  int       reports_checked = 0;
  int       halts_seen = 0;
  int       ticks_sent = 0;
  int       writes_sent = 0;
  int       chan_sent = 0;
  int       ignored_sent = 0;
  int       out_hold = 0;
  int       stuck_cycles = 0;
  tick_report_t got_report;
  tick_report_t want_report;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // print one mismatch line and count it
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // item layout of in_tdata, lowest field first
  function automatic logic [IN_TDATA_W-1:0] pack_item(
    input logic [7:0] now_v, input logic [5:0] entry_v, input logic level_v,
    input logic [7:0] dur_v, input logic [7:0] rel_v, input logic [5:0] next_v,
    input logic [2:0] chan_v, input logic en_v);
    return {7'b0, en_v, chan_v, next_v, rel_v, dur_v, level_v, entry_v, now_v};
  endfunction

  // durations lean toward short periods so that chains advance often
  function automatic logic [7:0] pick_duration();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 8'd0;
    if (sel <= 5) return 8'($urandom_range(1, 20));
    return 8'($urandom_range(0, 255));
  endfunction

  // expected effect of one tick on the shadow state
  task automatic predict_tick(input bit [7:0] now_v);
    bit [7:0] delta;
    bit [7:0] soonest;
    bit [7:0] changed;
    bit [7:0] vals;
    bit [7:0] halted;
    bit [7:0] cr;
    bit [7:0] rem;
    bit [8:0] sum;
    bit [5:0] e;
    bit       gave_up;
    int       steps;
    tick_report_t r;
    delta   = now_v - prev_now;
    soonest = 8'hff;
    changed = '0;
    vals    = '0;
    halted  = '0;
    prev_now = now_v;
    for (int c = 0; c < NUM_CH; c++) begin
      if (ch_run[c]) begin
        e = ch_pos[c];
        sum = {1'b0, ch_credit[c]} + {1'b0, delta};
        cr = (sum > 9'h0ff) ? 8'hff : sum[7:0];
        steps = 0;
        gave_up = 1'b0;
        // advance while the credit covers the current period
        while (!gave_up && cr >= dur_tab[e]) begin
          if (steps >= NUM_ENT) begin
            ch_run[c] = 1'b0;
            halted[c] = 1'b1;
            gave_up = 1'b1;
          end else begin
            steps++;
            e = link_tab[e];
            changed[c] = 1'b1;
            vals[c] = lvl_tab[e];
            cr = '0;
            dur_tab[e] = rel_tab[e];
          end
        end
        ch_pos[c] = e;
        ch_credit[c] = cr;
        if (ch_run[c]) begin
          rem = dur_tab[e] - cr;
          if (rem < soonest) soonest = rem;
        end
      end
    end
    pins = (pins & ~changed) | vals;
    r.port     = pins;
    r.changed  = changed;
    r.next_evt = now_v + soonest;
    r.halted   = halted;
    expected_reports.push_back(r);
  endtask

  // shadow update for one accepted transaction
  task automatic apply_item(input logic [1:0] op, input logic [IN_TDATA_W-1:0] d);
    case (op)
      OP_TICK: begin
        ticks_sent++;
        predict_tick(d[7:0]);
      end
      OP_WRITE: begin
        writes_sent++;
        lvl_tab[d[13:8]]  = d[14];
        dur_tab[d[13:8]]  = d[22:15];
        rel_tab[d[13:8]]  = d[30:23];
        link_tab[d[13:8]] = d[36:31];
      end
      OP_CHAN: begin
        chan_sent++;
        if (d[40]) begin
          ch_pos[d[39:37]]    = d[13:8];
          ch_credit[d[39:37]] = '0;
          ch_run[d[39:37]]    = 1'b1;
        end else begin
          ch_run[d[39:37]] = 1'b0;
        end
      end
      default: ignored_sent++;
    endcase
  endtask

  // send one item and wait for its handshake
  task automatic send_item(input logic [1:0] op, input logic [IN_TDATA_W-1:0] d);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    apply_item(op, d);
  endtask

  // unused fields of each item carry random bits
  task automatic send_tick(input logic [7:0] now_v);
    cur_now = now_v;
    send_item(OP_TICK, pack_item(now_v, 6'($urandom), 1'($urandom), 8'($urandom),
                                 8'($urandom), 6'($urandom), 3'($urandom), 1'($urandom)));
  endtask

  task automatic send_write(input logic [5:0] entry_v, input logic level_v,
                            input logic [7:0] dur_v, input logic [7:0] rel_v,
                            input logic [5:0] next_v);
    send_item(OP_WRITE, pack_item(8'($urandom), entry_v, level_v, dur_v, rel_v, next_v,
                                  3'($urandom), 1'($urandom)));
  endtask

  task automatic send_chan(input logic [2:0] chan_v, input logic en_v,
                           input logic [5:0] entry_v);
    send_item(OP_CHAN, pack_item(8'($urandom), entry_v, 1'($urandom), 8'($urandom),
                                 8'($urandom), 6'($urandom), chan_v, en_v));
  endtask

  // ticks with every channel stopped, at both ends of the time range
  task automatic test_idle_ticks();
    send_tick(8'd0);
    send_tick(8'd255);
  endtask

  // every table entry is written before any channel runs
  task automatic test_table_preload();
    for (int e = 0; e < NUM_ENT; e++) begin
      if (e == NUM_ENT - 1)
        send_write(6'(e), 1'b1, 8'hff, 8'hff, 6'(e));
      else
        send_write(6'(e), 1'($urandom), pick_duration(), pick_duration(), 6'($urandom));
    end
  endtask

  // two-period loop on channel 0, with an advance on the boundary
  task automatic test_two_period_chain();
    send_write(6'd0, 1'b1, 8'd3, 8'd5, 6'd1);
    send_write(6'd1, 1'b0, 8'd4, 8'd4, 6'd0);
    send_chan(3'd0, 1'b1, 6'd0);
    send_tick(cur_now + 8'd2);
    send_tick(cur_now + 8'd1);
    send_tick(cur_now + 8'd4);
    send_tick(cur_now + 8'd9);
  endtask

  // credit saturating at full scale and time wrapping past zero
  task automatic test_saturation_and_wrap();
    send_write(6'd62, 1'b1, 8'hff, 8'hff, 6'd62);
    send_chan(3'd7, 1'b1, 6'd62);
    send_tick(cur_now + 8'd200);
    send_tick(cur_now + 8'd200);
    send_tick(8'd5);
  endtask

  // a loop of zero durations halts the channel
  task automatic test_zero_duration_chain();
    send_write(6'd40, 1'b1, 8'd0, 8'd0, 6'd41);
    send_write(6'd41, 1'b0, 8'd0, 8'd0, 6'd40);
    send_chan(3'd3, 1'b1, 6'd40);
    send_tick(cur_now + 8'd1);
  endtask

  // stop keeps entry and credit, restart clears the credit
  task automatic test_stop_and_restart();
    send_chan(3'd0, 1'b0, 6'd0);
    send_tick(cur_now + 8'd7);
    send_chan(3'd0, 1'b1, 6'd1);
    send_tick(cur_now + 8'd3);
  endtask

  // the unused opcode leaves all state alone
  task automatic test_unknown_op();
    send_item(OP_NONE, {7'b0, {41{1'b1}}});
    send_item(OP_NONE, {7'b0, 9'($urandom), 32'($urandom)});
    send_tick(cur_now + 8'd1);
  endtask

  // random mix, half of it ticks on a steadily advancing clock
  task automatic test_random_traffic(input int count);
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        if ($urandom_range(0, 9) == 0)
          send_tick(8'($urandom));
        else
          send_tick(cur_now + 8'($urandom_range(0, 24)));
      end else if (sel < 75) begin
        send_write(6'($urandom), 1'($urandom), pick_duration(), pick_duration(),
                   6'($urandom));
      end else if (sel < 95) begin
        send_chan(3'($urandom), ($urandom_range(0, 3) != 0), 6'($urandom));
      end else begin
        send_item(OP_NONE, {7'b0, 9'($urandom), 32'($urandom)});
      end
    end
  endtask

  // sender holds off until every report is back
  task automatic test_pause_for_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  // output side stalls in short bursts
  always @(posedge clk) begin
    if (out_hold > 0) begin
      out_hold--;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_hold = $urandom_range(1, 3) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // compare each report with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_report = out_tdata;
      if (expected_reports.size() == 0) begin
        report_mismatch("report with no tick pending, tdata", int'(out_tdata), 0);
      end else begin
        want_report = expected_reports.pop_front();
        reports_checked++;
        if (want_report.halted != 0) halts_seen++;
        if (got_report.port != want_report.port)
          report_mismatch("port_value", got_report.port, want_report.port);
        if (got_report.changed != want_report.changed)
          report_mismatch("changed_mask", got_report.changed, want_report.changed);
        if (got_report.next_evt != want_report.next_evt)
          report_mismatch("next_event_time", got_report.next_evt, want_report.next_evt);
        if (got_report.halted != want_report.halted)
          report_mismatch("halted_mask", got_report.halted, want_report.halted);
      end
    end
  end

  // watchdog on cycles without any transaction while work is outstanding
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (!in_tvalid && expected_reports.size() == 0))
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("multichannel_level_sequencer_top regression: fail");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_ticks();
    test_table_preload();
    test_two_period_chain();
    test_saturation_and_wrap();
    test_zero_duration_chain();
    test_stop_and_restart();
    test_unknown_op();
    idle_on = 1'b1;
    test_random_traffic(160);
    test_pause_for_drain();
    test_random_traffic(120);
    idle_on = 1'b0;
    test_random_traffic(80);
    in_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("sent %0d ticks, %0d table writes, %0d channel commands, %0d ignored items",
             ticks_sent, writes_sent, chan_sent, ignored_sent);
    $display("checked %0d tick reports, %0d of them with halted channels",
             reports_checked, halts_seen);
    if (errors == 0) begin
      $display("multichannel_level_sequencer_top regression: pass");
    end else begin
      $display("multichannel_level_sequencer_top regression: fail");
    end
    $finish;
  end

endmodule
